// ----- hdl/smos_pkg.sv -----
// Package for the sliding median offset scaler.
// Holds field widths, fixed constants and the link type between sorter cells.
// No dependencies.
package smos_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int READING_W = 9;
    localparam int SCALE_SHIFT = 3;

    typedef logic [SAMPLE_W-1:0]  sample_t;
    typedef logic [READING_W-1:0] reading_t;

    // Zero offset after reset, in raw sample units.
    localparam sample_t OFFSET_RESET = 12'd500;

    // What one sorter cell shows its right-hand neighbour.
    typedef struct packed {
        sample_t val;   // value held by the cell
        logic    full;  // cell holds a sorted value
        logic    gt;    // cell's value must move right for the value being inserted
    } cell_link_t;

endpackage

// ----- hdl/smos_sort_cell.sv -----
// One cell of the insertion sorter row for the sliding median offset scaler.
// Depends on smos_pkg for the sample and link types.
module smos_sort_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic                ins,
    input  smos_pkg::sample_t   x,
    input  smos_pkg::cell_link_t prev,
    output smos_pkg::cell_link_t own
);
    import smos_pkg::*;

    sample_t val_reg;
    sample_t val_next;
    logic    full_reg;
    logic    full_next;
    logic    gt;

    // An empty cell always sits after the incoming value.
    assign gt = !full_reg || (val_reg > x);

    always_comb
    begin
        val_next  = val_reg;
        full_next = full_reg;
        if (clear)
        begin
            full_next = 1'b0;
        end
        else if (ins)
        begin
            full_next = full_reg | prev.full;
            if (gt)
            begin
                val_next = prev.gt ? prev.val : x;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign own = '{val: val_reg, full: full_reg, gt: gt};

endmodule

// ----- hdl/sliding_median_offset_scaler_unit.sv -----
// An accepted input beat passes through the sorting and result states before its
// output beat is registered; no new beat is taken until the controller is idle again.
// The sorting time is set by the sorter row, which takes one window value per cycle.
// Reset (rst_n, asynchronous, active low) zeroes the window, sets zero_offset to 500
// and empties the sorter and the output register.
// Depends on smos_pkg and smos_sort_cell.
module sliding_median_offset_scaler_unit #(
    parameter int WINDOW_LEN = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: zero_offset register.
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] sample, [15:12] zero
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [11:0] median_raw, [20:12] reading, [23:21] zero
);
    import smos_pkg::*;

    localparam int CNT_W   = $clog2(WINDOW_LEN);
    localparam int MID_LO  = (WINDOW_LEN - 1) / 2;
    localparam int MID_HI  = WINDOW_LEN / 2;

    // The controller: idle and ready for a beat, feeding the sorter, then
    // forming the result once the output register is free.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SORT = 3'b010,
        ST_CALC = 3'b100
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    sample_t    offset_reg;

    // The window is a shift line, oldest sample in entry 0. While sorting it
    // rotates once per cycle so that entry 0 feeds the sorter and, after a full
    // turn, every sample is back in place.
    sample_t    window_reg [WINDOW_LEN];

    logic       accept;
    logic       rotate;
    logic       sort_clear;
    logic       sort_ins;

    cell_link_t link [WINDOW_LEN+1];

    logic       m_tvalid_reg;
    sample_t    median_reg;
    reading_t   reading_reg;
    logic       out_load;

    logic [SAMPLE_W:0] mid_sum;
    sample_t    median;
    logic [SAMPLE_W:0] diff;
    reading_t   reading;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign rotate   = (state_reg == ST_SORT);
    assign sort_clear = accept;
    assign sort_ins = rotate;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RESET;
        end
        else if (cfg_wr_en)
        begin
            offset_reg <= cfg_wr_data;
        end
    end

    // Window shift line: a new sample enters at the top on an accepted beat,
    // the oldest entry wraps round to the top while sorting.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (accept || rotate)
        begin
            for (int i = 0; i < WINDOW_LEN - 1; i++)
            begin
                window_reg[i] <= window_reg[i+1];
            end
            window_reg[WINDOW_LEN-1] <= accept ? s_tdata[SAMPLE_W-1:0] : window_reg[0];
        end
    end

    // Insertion sorter: a row of cells kept in ascending order. Each cycle the
    // value at the head of the window is broadcast and every cell either keeps
    // its value, takes its left neighbour's value or takes the new value.
    assign link[0] = '{val: '0, full: 1'b1, gt: 1'b0};

    for (genvar g = 0; g < WINDOW_LEN; g++)
    begin : g_cell
        smos_sort_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .clear (sort_clear),
            .ins   (sort_ins),
            .x     (window_reg[0]),
            .prev  (link[g]),
            .own   (link[g+1])
        );
    end

    // Median of the two middle cells, then the offset removal and scaling.
    // A 12-bit median shifted right by three is at most 511, so the clamp at
    // 999 can never act and is not built.
    assign mid_sum = {1'b0, link[MID_LO+1].val} + {1'b0, link[MID_HI+1].val};
    assign median  = mid_sum[SAMPLE_W:1];
    assign diff    = {1'b0, median} - {1'b0, offset_reg};
    assign reading = (median > offset_reg) ? diff[SAMPLE_W-1:SCALE_SHIFT] : '0;

    assign out_load = (state_reg == ST_CALC) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SORT;
                    cnt_next   = '0;
                end
            end
            ST_SORT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WINDOW_LEN - 1))
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Output register: holds a finished beat until the downstream side takes it,
    // while the next input beat is already being sorted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            median_reg  <= median;
            reading_reg <= reading;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, reading_reg, median_reg};

endmodule

// ----- test/tb_sliding_median_offset_scaler_unit.sv -----
// Self-checking testbench for sliding_median_offset_scaler_unit: drives sample beats,
// rewrites zero_offset between phases and checks every output beat against a predictor.
// Depends on smos_pkg and the RTL of the block under test.
module tb_sliding_median_offset_scaler_unit;

    import smos_pkg::*;

    // The block is built with its default window length; the predictor mirrors it.
    localparam int WIN           = 10;
    localparam int READING_CLAMP = 999;
    localparam int N_PHASES      = 8;
    localparam int PHASE_BEATS   = 190;
    // Cycles waited once no output beat is expected, before a register write or the end of the run.
    localparam int SETTLE_CYCLES = 3 * (WIN + 2);

    // One expected output beat.
    typedef struct packed {
        sample_t  median;
        reading_t reading;
    } reading_beat_t;

    // The scoreboard keeps its own copy of the window and of zero_offset. Every
    // accepted sample beat produces one expectation; every output beat is
    // compared with the oldest one.
    class median_scoreboard;
        sample_t       win[WIN];
        sample_t       offset;
        reading_beat_t pending[$];
        int            errors;
        int            checked;

        function new();
            foreach (win[i])
                win[i] = '0;
            offset  = OFFSET_RESET;
            errors  = 0;
            checked = 0;
        endfunction

        function void set_offset(sample_t v);
            offset = v;
        endfunction

        // Shifts the sample in (oldest first) and works out the median and reading.
        function void note_sample(sample_t v);
            sample_t           sorted[WIN];
            sample_t           tmp;
            logic [SAMPLE_W:0] pair_sum;
            int unsigned       scaled;
            reading_beat_t     r;
            for (int i = 0; i < WIN - 1; i++)
                win[i] = win[i + 1];
            win[WIN - 1] = v;
            sorted = win;
            for (int p = 0; p < WIN - 1; p++)
            begin
                for (int i = 0; i < WIN - 1 - p; i++)
                begin
                    if (sorted[i] > sorted[i + 1])
                    begin
                        tmp           = sorted[i];
                        sorted[i]     = sorted[i + 1];
                        sorted[i + 1] = tmp;
                    end
                end
            end
            // For an even length these are two neighbours; for an odd one the same cell.
            pair_sum = {1'b0, sorted[(WIN - 1) / 2]} + {1'b0, sorted[WIN / 2]};
            r.median = pair_sum[SAMPLE_W:1];
            if (r.median > offset)
                scaled = int'(r.median - offset) >> SCALE_SHIFT;
            else
                scaled = 0;
            if (scaled > READING_CLAMP)
                scaled = READING_CLAMP;
            r.reading = scaled[READING_W-1:0];
            pending.push_back(r);
        endfunction

        function void check_result(sample_t median, reading_t reading);
            reading_beat_t exp_beat;
            if (pending.size() == 0)
            begin
                $display("%0t: output beat with nothing expected: median_raw %0d reading %0d",
                         $time, median, reading);
                errors++;
                return;
            end
            exp_beat = pending.pop_front();
            checked++;
            if (median !== exp_beat.median)
            begin
                $display("%0t: median_raw mismatch: expected %0d, actual %0d",
                         $time, exp_beat.median, median);
                errors++;
            end
            if (reading !== exp_beat.reading)
            begin
                $display("%0t: reading mismatch: expected %0d, actual %0d",
                         $time, exp_beat.reading, reading);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [11:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [11:0] sample, [15:12] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [11:0] median_raw, [20:12] reading, [23:21] zero

    median_scoreboard sb;

    // When set, neither side inserts idle cycles.
    bit steady;
    int beats_sent;
    int offsets_used;

    sliding_median_offset_scaler_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The output side stalls with a chance of roughly 11 percent unless a steady
    // stretch is running. It changes on the falling edge like every other input.
    always @(negedge clk)
    begin
        m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 11);
    end

    // Output monitor: a beat moves at a rising edge with m_tvalid and m_tready high.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[11:0], m_tdata[20:12]);
    end

    // Offers one sample beat and holds it until the block takes it. The valid line
    // stays high after acceptance until the next falling edge, where the next call
    // either presents new data or drops it for an idle cycle, so it is never lowered
    // and raised in the same step.
    task automatic push_sample(input sample_t v);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 11)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, v};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_sample(v);
        beats_sent++;
    endtask

    // Drops valid, waits for every expected output beat and then lets the block's
    // latency run out, so that it is idle for a register write or for the end.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_offset(input sample_t v);
        drain_results();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        sb.set_offset(v);
        offsets_used++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // A sample close to the current offset, so that the median straddles it.
    function automatic sample_t near_offset(input int spread);
        int v;
        v = int'(sb.offset) + int'($urandom_range(2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return sample_t'(v);
    endfunction

    // Random phase: a mix of full-range samples, samples close to the offset, the
    // extremes and runs of one value that pull the whole window onto a level.
    task automatic run_phase(input int n_beats);
        int      done;
        int      kind;
        int      run_len;
        sample_t level;
        done = 0;
        while (done < n_beats)
        begin
            kind = $urandom_range(99);
            if (kind < 40)
            begin
                push_sample(sample_t'($urandom_range(4095)));
                done++;
            end
            else if (kind < 75)
            begin
                push_sample(near_offset(40));
                done++;
            end
            else if (kind < 85)
            begin
                push_sample($urandom_range(1) ? 12'hFFF : 12'h000);
                done++;
            end
            else
            begin
                run_len = $urandom_range(10, 4);
                level   = $urandom_range(1) ? near_offset(16) : sample_t'($urandom_range(4095));
                for (int i = 0; i < run_len; i++)
                    push_sample(level);
                done += run_len;
            end
        end
    endtask

    sample_t phase_offset[N_PHASES];

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        steady       = 1'b0;
        beats_sent   = 0;
        offsets_used = 0;
        sb           = new();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset offset of 500. The window starts all zero, so
        // the first beats see the median pulled down by the cleared entries; a
        // half-full window of 4095 gives the truncated mean of 0 and 4095.
        push_sample(12'd0);
        repeat (5) push_sample(12'hFFF);
        push_sample(12'hFFF);
        // A window dominated by the offset itself: median equal to it, reading zero.
        repeat (6) push_sample(OFFSET_RESET);
        // Just above the offset by one step of eight: reading one.
        repeat (6) push_sample(OFFSET_RESET + 12'd8);
        push_sample(12'hAAA);
        push_sample(12'h555);
        push_sample(OFFSET_RESET + 12'd1);

        // Offsets per phase: both extremes, one above the bottom, one below the top,
        // the reset value written explicitly and a few random ones.
        phase_offset[0] = 12'd0;
        phase_offset[1] = 12'hFFF;
        phase_offset[2] = 12'd1;
        phase_offset[3] = OFFSET_RESET;
        phase_offset[4] = sample_t'($urandom_range(4095));
        phase_offset[5] = 12'hFFE;
        phase_offset[6] = sample_t'($urandom_range(4095));
        phase_offset[7] = sample_t'($urandom_range(4095));

        for (int p = 0; p < N_PHASES; p++)
        begin
            apply_offset(phase_offset[p]);
            // One phase runs without any idle cycles on either side.
            steady = (p == 3);
            run_phase(PHASE_BEATS);
        end
        steady = 1'b0;

        drain_results();

        if (sb.pending.size() != 0)
        begin
            $display("%0t: %0d expected output beats never arrived", $time, sb.pending.size());
            sb.errors += sb.pending.size();
        end

        $display("Sent %0d sample beats across %0d zero_offset settings, checked %0d output beats.",
                 beats_sent, offsets_used, sb.checked);
        if (sb.errors == 0)
            $display("sliding_median_offset_scaler_unit verification clean");
        else
            $display("sliding_median_offset_scaler_unit verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run with the random stalls above.
    initial
    begin
        #4800000;
        $display("%0t: timeout with %0d output beats outstanding", $time, sb.pending.size());
        $display("sliding_median_offset_scaler_unit verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/smos_pkg.sv
hdl/smos_sort_cell.sv
hdl/sliding_median_offset_scaler_unit.sv
test/tb_sliding_median_offset_scaler_unit.sv
